/* rtl/core/delta_list_timer_queue_top_assert.svh */
// Assertion macros for the delta list timer queue.
// Used by the top level; expects clk and rst in scope.
`ifndef DELTA_LIST_TIMER_QUEUE_TOP_ASSERT_SVH
`define DELTA_LIST_TIMER_QUEUE_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define DLTQ_ASSERT_SAME(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("timer queue check failed");

// Condition implies consequence in the next cycle.
`define DLTQ_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("timer queue check failed");

`endif

/* rtl/core/dltq_pkg.sv */
// Shared types, codes and helpers for the delta list timer queue.
// No dependencies.
package dltq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int TAG_BITS_DEF = 16;
  localparam int MAX_OUT      = 16;

  localparam logic [1:0] CMD_SCHEDULE = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_FIND     = 2'd2;
  localparam logic [1:0] CMD_CANCEL   = 2'd3;

  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EXPIRED   = 3'd4;
  localparam logic [2:0] ST_NONE_DUE  = 3'd5;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TAKE_LEFT,
    CELL_TAKE_RIGHT,
    CELL_LOAD_BOTH,
    CELL_LOAD_DELTA
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     fold;
  } cell_ctrl_t;

  // Clamp a 33-bit signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -33'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/dltq_cell.sv */
// One slot of the delta list: tag and relative delay.
// Depends on dltq_pkg; shifts with its neighbors on insert and remove.
module dltq_cell #(
  parameter int TAG_BITS = dltq_pkg::TAG_BITS_DEF
) (
  input  logic                       clk,
  input  dltq_pkg::cell_ctrl_t       ctrl,
  input  logic [TAG_BITS-1:0]        bus_tag,
  input  logic signed [31:0]         bus_delta,
  input  logic [TAG_BITS-1:0]        left_tag,
  input  logic signed [31:0]         left_delta,
  input  logic [TAG_BITS-1:0]        right_tag,
  input  logic signed [31:0]         right_delta,
  output logic [TAG_BITS-1:0]        tag,
  output logic signed [31:0]         delta
);

  logic signed [32:0] fold_sum;

  assign fold_sum = {right_delta[31], right_delta} + {delta[31], delta};

  always_ff @(posedge clk) begin
    case (ctrl.op)
      dltq_pkg::CELL_TAKE_LEFT: begin
        tag   <= left_tag;
        delta <= left_delta;
      end
      dltq_pkg::CELL_TAKE_RIGHT: begin
        tag   <= right_tag;
        // fold the removed delay into the successor
        delta <= ctrl.fold ? dltq_pkg::sat33(fold_sum) : right_delta;
      end
      dltq_pkg::CELL_LOAD_BOTH: begin
        tag   <= bus_tag;
        delta <= bus_delta;
      end
      dltq_pkg::CELL_LOAD_DELTA: begin
        delta <= bus_delta;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/delta_list_timer_queue_top.sv */
// Delta list timer queue: a row of slot cells plus the command sequencer.
// Depends on dltq_pkg, dltq_cell and delta_list_timer_queue_top_assert.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries command, entry_tag, amount.
//   Output channel (out_valid/out_ready) carries status, result_tag,
//   remaining and last; last marks the final result of a command.
//   cfg_write_en/cfg_write_data set max_entries (0: only CAPACITY limits).
// Timing:
//   One command at a time. Schedule walks the list one slot a cycle.
//   Tick first adjusts the head, then pops one expired entry per cycle
//   while the output is free (at most 16 per tick).
//   Insert and remove shift the cells from the target slot onward.
// Reset:
//   rst clears the entry count, max_entries and the output valid.
// Stall:
//   A result waits in the output register; the sequencer holds until the
//   receiver takes it, and the next command is taken once the last result
//   of the current one has been registered.
module delta_list_timer_queue_top #(
  parameter int CAPACITY = dltq_pkg::CAPACITY_DEF,
  parameter int TAG_BITS = dltq_pkg::TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [4:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] entry_tag,
  input  logic [30:0] amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] result_tag,
  output logic [30:0] remaining,
  output logic        last
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = 33 + IDX_W;
  localparam int N_W   = $clog2(dltq_pkg::MAX_OUT + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCHED_SCAN,
    S_SCHED_INS,
    S_TICK_SUB,
    S_TICK_POP,
    S_FIND_SCAN
  } state_t;

  state_t                    state, state_next;
  logic [CNT_W-1:0]          pending_count, pending_count_next;
  logic [4:0]                max_entries;
  logic [CNT_W-1:0]          idx, idx_next;
  logic [IDX_W-1:0]          pos, pos_next;
  logic [IDX_W-1:0]          cell_pos;
  logic signed [31:0]        delay, delay_next;
  logic signed [SUM_W-1:0]   sum, sum_next;
  logic [N_W-1:0]            n_out, n_out_next;
  logic [1:0]                cmd_q;
  logic [TAG_BITS-1:0]       tag_q;
  logic [30:0]               amount_q;

  logic                      emit;
  logic [2:0]                emit_status;
  logic [15:0]               emit_tag;
  logic [30:0]               emit_rem;
  logic                      emit_last;

  logic                      ins_en, rem_en, setd_en, fold_en;
  logic [TAG_BITS-1:0]       bus_tag;
  logic signed [31:0]        bus_delta;

  logic [TAG_BITS-1:0]       cell_tag   [CAPACITY];
  logic signed [31:0]        cell_delta [CAPACITY];
  dltq_pkg::cell_ctrl_t      cell_ctrl  [CAPACITY];

  logic                      out_free, in_fire, list_full;
  logic [TAG_BITS-1:0]       cur_tag;
  logic signed [31:0]        cur_delta, head_delta, next_head;
  logic signed [SUM_W-1:0]   sum_add;
  logic                      more_due;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign list_full = (pending_count >= CNT_W'(CAPACITY)) ||
                     ((max_entries != 5'd0) && (32'(pending_count) >= 32'(max_entries)));

  assign cur_tag    = cell_tag[idx[IDX_W-1:0]];
  assign cur_delta  = cell_delta[idx[IDX_W-1:0]];
  assign head_delta = cell_delta[0];
  assign sum_add    = sum + SUM_W'(cur_delta);
  // head delay after popping the head, with a missed head folded in
  assign next_head  = head_delta[31] ?
                      dltq_pkg::sat33({cell_delta[1][31], cell_delta[1]} +
                                      {head_delta[31], head_delta}) :
                      cell_delta[1];
  assign more_due   = (pending_count > CNT_W'(2'd1)) && (next_head <= 32'sd0) &&
                      (n_out != N_W'(dltq_pkg::MAX_OUT - 1));

  genvar j;
  generate
    for (j = 0; j < CAPACITY; j++) begin : g_cell
      logic [TAG_BITS-1:0] l_tag, r_tag;
      logic signed [31:0]  l_delta, r_delta;

      if (j == 0) begin : g_first
        assign l_tag   = '0;
        assign l_delta = '0;
      end else begin : g_left
        assign l_tag   = cell_tag[j-1];
        assign l_delta = cell_delta[j-1];
      end
      if (j == CAPACITY - 1) begin : g_lastc
        assign r_tag   = '0;
        assign r_delta = '0;
      end else begin : g_right
        assign r_tag   = cell_tag[j+1];
        assign r_delta = cell_delta[j+1];
      end

      always_comb begin
        cell_ctrl[j].op   = dltq_pkg::CELL_HOLD;
        cell_ctrl[j].fold = 1'b0;
        if (ins_en) begin
          if (IDX_W'(j) > cell_pos) begin
            cell_ctrl[j].op = dltq_pkg::CELL_TAKE_LEFT;
          end else if (IDX_W'(j) == cell_pos) begin
            cell_ctrl[j].op = dltq_pkg::CELL_LOAD_BOTH;
          end
        end else if (rem_en) begin
          if (IDX_W'(j) >= cell_pos) begin
            cell_ctrl[j].op = dltq_pkg::CELL_TAKE_RIGHT;
          end
          cell_ctrl[j].fold = fold_en && (IDX_W'(j) == cell_pos);
        end else if (setd_en && (IDX_W'(j) == cell_pos)) begin
          cell_ctrl[j].op = dltq_pkg::CELL_LOAD_DELTA;
        end
      end

      dltq_cell #(
        .TAG_BITS(TAG_BITS)
      ) u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[j]),
        .bus_tag    (bus_tag),
        .bus_delta  (bus_delta),
        .left_tag   (l_tag),
        .left_delta (l_delta),
        .right_tag  (r_tag),
        .right_delta(r_delta),
        .tag        (cell_tag[j]),
        .delta      (cell_delta[j])
      );
    end
  endgenerate

  always_comb begin
    state_next         = state;
    pending_count_next = pending_count;
    idx_next           = idx;
    pos_next           = pos;
    cell_pos           = pos;
    delay_next         = delay;
    sum_next           = sum;
    n_out_next         = n_out;
    emit               = 1'b0;
    emit_status        = dltq_pkg::ST_ACCEPTED;
    emit_tag           = 16'(tag_q);
    emit_rem           = '0;
    emit_last          = 1'b1;
    ins_en             = 1'b0;
    rem_en             = 1'b0;
    setd_en            = 1'b0;
    fold_en            = 1'b0;
    bus_tag            = tag_q;
    bus_delta          = delay;

    case (state)
      S_IDLE: begin
        if (in_fire) begin
          idx_next   = '0;
          delay_next = 32'({1'b0, amount});
          sum_next   = '0;
          n_out_next = '0;
          case (command)
            dltq_pkg::CMD_SCHEDULE: state_next = S_SCHED_SCAN;
            dltq_pkg::CMD_TICK:     state_next = S_TICK_SUB;
            default:                state_next = S_FIND_SCAN;
          endcase
        end
      end
      S_SCHED_SCAN: begin
        if (list_full) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = dltq_pkg::ST_FULL;
            state_next  = S_IDLE;
          end
        end else if (idx == pending_count) begin
          pos_next   = idx[IDX_W-1:0];
          state_next = S_SCHED_INS;
        end else if (cur_delta > delay) begin
          // split this slot's delay around the new entry
          setd_en    = 1'b1;
          bus_delta  = cur_delta - delay;
          pos_next   = idx[IDX_W-1:0];
          state_next = S_SCHED_INS;
        end else begin
          if (cur_delta > 32'sd0) begin
            delay_next = delay - cur_delta;
          end
          idx_next = idx + CNT_W'(1'b1);
        end
      end
      S_SCHED_INS: begin
        if (out_free) begin
          ins_en             = 1'b1;
          pending_count_next = pending_count + CNT_W'(1'b1);
          emit               = 1'b1;
          emit_status        = dltq_pkg::ST_ACCEPTED;
          state_next         = S_IDLE;
        end
      end
      S_TICK_SUB: begin
        if (pending_count != '0) begin
          setd_en   = 1'b1;
          bus_delta = dltq_pkg::sat33({head_delta[31], head_delta} -
                                      33'({2'b0, amount_q}));
        end
        state_next = S_TICK_POP;
      end
      S_TICK_POP: begin
        if (out_free) begin
          emit = 1'b1;
          if ((pending_count == '0) || (head_delta > 32'sd0)) begin
            emit_status = dltq_pkg::ST_NONE_DUE;
            emit_tag    = '0;
            state_next  = S_IDLE;
          end else begin
            emit_status        = dltq_pkg::ST_EXPIRED;
            emit_tag           = 16'(cell_tag[0]);
            emit_last          = !more_due;
            rem_en             = 1'b1;
            fold_en            = head_delta[31];
            pending_count_next = pending_count - CNT_W'(1'b1);
            n_out_next         = n_out + N_W'(1'b1);
            if (!more_due) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      S_FIND_SCAN: begin
        if (idx == pending_count) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = dltq_pkg::ST_NOT_FOUND;
            state_next  = S_IDLE;
          end
        end else if (cur_tag == tag_q) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = dltq_pkg::ST_FOUND;
            if (sum_add < 0) begin
              emit_rem = '0;
            end else if (sum_add > SUM_W'(32'h7FFF_FFFF)) begin
              emit_rem = 31'h7FFF_FFFF;
            end else begin
              emit_rem = sum_add[30:0];
            end
            if (cmd_q == dltq_pkg::CMD_CANCEL) begin
              rem_en             = 1'b1;
              fold_en            = 1'b1;
              pending_count_next = pending_count - CNT_W'(1'b1);
            end
            state_next = S_IDLE;
          end
        end else begin
          sum_next = sum_add;
          idx_next = idx + CNT_W'(1'b1);
        end
      end
      default: state_next = S_IDLE;
    endcase

    // head ops and scan ops share the position bus
    if (state == S_TICK_SUB || state == S_TICK_POP) begin
      cell_pos = '0;
    end else if (state == S_FIND_SCAN || (state == S_SCHED_SCAN && setd_en)) begin
      cell_pos = idx[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pending_count <= '0;
      max_entries   <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      pending_count <= pending_count_next;
      if (cfg_write_en) begin
        max_entries <= cfg_write_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    delay <= delay_next;
    sum   <= sum_next;
    n_out <= n_out_next;
    if (state == S_SCHED_SCAN || state == S_IDLE) begin
      pos <= pos_next;
    end
    if (in_fire) begin
      cmd_q    <= command;
      tag_q    <= TAG_BITS'(entry_tag);
      amount_q <= amount;
    end
    if (emit) begin
      status     <= emit_status;
      result_tag <= emit_tag;
      remaining  <= emit_rem;
      last       <= emit_last;
    end
  end

`include "delta_list_timer_queue_top_assert.svh"

  `DLTQ_ASSERT_SAME(a_count_bound, 1'b1, pending_count <= CNT_W'(CAPACITY))
  `DLTQ_ASSERT_NEXT(a_insert_count, (state == S_SCHED_INS) && out_free,
    pending_count == $past(pending_count) + CNT_W'(1'b1))
  `DLTQ_ASSERT_SAME(a_none_due_last, out_valid && (status == dltq_pkg::ST_NONE_DUE), last)

endmodule
